[design/pid_position_motor_drive_defines.svh]
// Shared assertion macros for the position drive checker.
`ifndef PID_POSITION_MOTOR_DRIVE_DEFINES_SVH
`define PID_POSITION_MOTOR_DRIVE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PMD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pmd_pkg.sv]
`default_nettype none

package pmd_pkg;

    // Defaults for the top-level parameters
    localparam int GAIN_FRAC_BITS_DEF = 16;
    localparam int PWM_MAX_DEF        = 255;

    // Port and field widths
    localparam int POS_W      = 32;
    localparam int TGT_W      = 16;
    localparam int DT_W       = 24;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 8;
    localparam int DUTY_OUT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int ERR_W      = 34;
    localparam int DELTA_W    = 35;
    localparam int ACC_W      = 64;
    localparam int MAG_A_W    = 64;
    localparam int MAG_B_W    = 32;
    localparam int TERM_MAG_W = 62;
    localparam int TERM_W     = TERM_MAG_W + 1;
    localparam int SUM_W      = 64;
    localparam int PWM_W      = 16;

    // Saturation bound of each multiplier product, 2^61
    localparam logic [TERM_MAG_W-1:0] TERM_LIMIT = {1'b1, {(TERM_MAG_W - 1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ACC_ADD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_MAG,
        ST_OUT
    } pmd_state_t;

    typedef enum logic [1:0] {
        OP_ACC,
        OP_PROP,
        OP_INTEG,
        OP_DERIV
    } pmd_op_t;

    typedef struct packed {
        logic                 start;
        logic [MAG_A_W-1:0]   a_mag;
        logic [MAG_B_W-1:0]   b_mag;
    } pmd_mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [TERM_MAG_W-1:0] dividend;
        logic [DT_W-1:0]       divisor;
    } pmd_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [TERM_MAG_W-1:0] value;
    } pmd_unit_rsp_t;

endpackage

`default_nettype wire

[design/pmd_mul.sv]
`default_nettype none

module pmd_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pmd_pkg::pmd_mul_req_t   req,
    output pmd_pkg::pmd_unit_rsp_t  rsp
);

    localparam int HALF_W  = pmd_pkg::MAG_A_W / 2;
    localparam int PROD_W  = HALF_W + pmd_pkg::MAG_B_W;
    localparam int HI_OK_W = pmd_pkg::TERM_MAG_W - 1 - HALF_W;
    localparam int TOT_W   = PROD_W + 1;

    logic [pmd_pkg::MAG_A_W-1:0]    a_reg;
    logic [pmd_pkg::MAG_B_W-1:0]    b_reg;
    logic [PROD_W-1:0]              lo_reg;
    logic [PROD_W-1:0]              hi_reg;
    logic [pmd_pkg::TERM_MAG_W-1:0] res_reg;
    logic [2:0]                     phase_reg;
    logic [2:0]                     phase_next;
    logic                           done_reg;

    logic [HALF_W-1:0]              half_op;
    logic [PROD_W-1:0]              prod;
    logic [TOT_W-1:0]               total;
    logic                           sat;
    logic [pmd_pkg::TERM_MAG_W-1:0] res_next;

    // Low half first, then high half, then combine
    assign phase_next = {phase_reg[1:0], req.start};
    assign half_op    = phase_reg[0] ? a_reg[HALF_W-1:0] : a_reg[pmd_pkg::MAG_A_W-1:HALF_W];
    assign prod       = PROD_W'(half_op) * PROD_W'(b_reg);

    // Join partial products and clamp at the term limit
    always_comb
    begin
        total = TOT_W'({hi_reg[HI_OK_W-1:0], {HALF_W{1'b0}}}) + TOT_W'(lo_reg);
        sat   = (|hi_reg[PROD_W-1:HI_OK_W]) || (total > TOT_W'(pmd_pkg::TERM_LIMIT));
        res_next = sat ? pmd_pkg::TERM_LIMIT : total[pmd_pkg::TERM_MAG_W-1:0];
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= phase_reg[2];
        end
    end

    // Operand and product registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a_mag;
            b_reg <= req.b_mag;
        end
        if (phase_reg[0])
        begin
            lo_reg <= prod;
        end
        if (phase_reg[1])
        begin
            hi_reg <= prod;
        end
        if (phase_reg[2])
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

[design/pmd_div.sv]
`default_nettype none

module pmd_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pmd_pkg::pmd_div_req_t   req,
    output pmd_pkg::pmd_unit_rsp_t  rsp
);

    localparam int N_W      = pmd_pkg::TERM_MAG_W;
    localparam int D_W      = pmd_pkg::DT_W;
    localparam int BITS_PER = 2;
    localparam int STEPS    = (N_W + BITS_PER - 1) / BITS_PER;
    localparam int Q_W      = STEPS * BITS_PER;
    localparam int CNT_W    = $clog2(STEPS + 1);

    logic [Q_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [Q_W-1:0]   quo_next;
    logic [D_W-1:0]   rem_next;

    // Two restoring steps per cycle: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        logic [D_W:0] trial;
        logic         fits;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < BITS_PER; i++)
        begin
            trial = {rem_next, quo_next[Q_W-1]};
            fits  = trial >= {1'b0, dvs_reg};
            if (fits)
            begin
                trial = trial - {1'b0, dvs_reg};
            end
            rem_next = trial[D_W-1:0];
            quo_next = {quo_next[Q_W-2:0], fits};
        end
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend, remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= Q_W'(req.dividend);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = quo_reg[N_W-1:0];

endmodule

`default_nettype wire

[design/pid_position_motor_drive.sv]
// Each transaction runs four passes through one 32x32 multiplier and, when elapsed_us is not 0,
// a divider retiring two quotient bits per cycle for the derivative term. in_ready is low from
// the accepted input transaction until the result is loaded into the output register.
// Reset (rst_n low, asynchronous): gains clear to 0, pwm_limit to 255, integral, last error
// and last direction to 0; the sequencer returns to idle and out_valid drops.
`default_nettype none

module pid_position_motor_drive #(
    parameter int GAIN_FRAC_BITS = pmd_pkg::GAIN_FRAC_BITS_DEF,
    parameter int PWM_MAX        = pmd_pkg::PWM_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pmd_pkg::POS_W-1:0]   encoder_count,
    input  logic signed [pmd_pkg::TGT_W-1:0]   target_position,
    input  logic [pmd_pkg::DT_W-1:0]           elapsed_us,
    input  logic                               fwd_limit_hit,
    input  logic                               rev_limit_hit,
    input  logic                               watchdog_trip,
    input  logic                               supervisor_halt,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pmd_pkg::DUTY_OUT_W-1:0]     pwm_duty,
    output logic                               reverse_dir,
    output logic                               drive_blocked,
    output logic signed [pmd_pkg::POS_W-1:0]   position_echo
);

    localparam int ERR_W    = pmd_pkg::ERR_W;
    localparam int DELTA_W  = pmd_pkg::DELTA_W;
    localparam int ACC_W    = pmd_pkg::ACC_W;
    localparam int ACC_X_W  = ACC_W + 1;
    localparam int TERM_W   = pmd_pkg::TERM_W;
    localparam int SUM_W    = pmd_pkg::SUM_W;
    localparam int DUTY_W   = SUM_W - GAIN_FRAC_BITS;
    localparam int PWM_W    = pmd_pkg::PWM_W;
    localparam int GAIN_W   = pmd_pkg::GAIN_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    // Configuration registers
    logic signed [GAIN_W-1:0]          gain_prop_reg;
    logic signed [GAIN_W-1:0]          gain_integ_reg;
    logic signed [GAIN_W-1:0]          gain_deriv_reg;
    logic [pmd_pkg::LIM_W-1:0]         pwm_limit_reg;

    // Sequencer
    pmd_pkg::pmd_state_t               state_reg;
    pmd_pkg::pmd_state_t               state_next;
    pmd_pkg::pmd_op_t                  op_reg;
    pmd_pkg::pmd_op_t                  op_next;

    // Loop state
    logic signed [ACC_W-1:0]           err_accum_reg;
    logic signed [ERR_W-1:0]           last_error_reg;
    logic                              last_dir_reg;

    // Step registers
    logic signed [pmd_pkg::POS_W-1:0]  pos_reg;
    logic [pmd_pkg::DT_W-1:0]          dt_reg;
    logic                              fwd_blk_reg;
    logic                              rev_blk_reg;
    logic                              all_blk_reg;
    logic signed [ERR_W-1:0]           err_reg;
    logic signed [DELTA_W-1:0]         delta_reg;
    logic signed [TERM_W-1:0]          acc_inc_reg;
    logic signed [TERM_W-1:0]          p_term_reg;
    logic signed [TERM_W-1:0]          i_term_reg;
    logic signed [TERM_W-1:0]          d_term_reg;
    logic [pmd_pkg::TERM_MAG_W-1:0]    d_mag_reg;
    logic signed [SUM_W-1:0]           sum_reg;
    logic [DUTY_W-1:0]                 duty_full_reg;
    logic                              fwd_dir_reg;

    // Output register
    logic                              out_valid_reg;
    logic [pmd_pkg::DUTY_OUT_W-1:0]    pwm_duty_reg;
    logic                              reverse_dir_reg;
    logic                              blocked_reg;
    logic signed [pmd_pkg::POS_W-1:0]  echo_reg;

    pmd_pkg::pmd_mul_req_t             mul_req;
    pmd_pkg::pmd_unit_rsp_t            mul_rsp;
    pmd_pkg::pmd_div_req_t             div_req;
    pmd_pkg::pmd_unit_rsp_t            div_rsp;

    logic                              in_fire;
    logic                              out_load;
    logic signed [ERR_W-1:0]           err_in;
    logic signed [DELTA_W-1:0]         delta_c;
    logic [ERR_W-1:0]                  err_mag;
    logic [DELTA_W-1:0]                delta_mag;
    logic [ACC_W-1:0]                  acc_mag;
    logic [GAIN_W-1:0]                 gp_mag;
    logic [GAIN_W-1:0]                 gi_mag;
    logic [GAIN_W-1:0]                 gd_mag;
    logic                              mul_neg;
    logic                              d_neg;
    logic signed [TERM_W-1:0]          mul_term;
    logic signed [TERM_W-1:0]          div_term;
    logic signed [ACC_X_W-1:0]         acc_sum;
    logic signed [ACC_W-1:0]           acc_next;
    logic signed [SUM_W-1:0]           sum_c;
    logic [SUM_W-1:0]                  sum_mag;
    logic [DUTY_W-1:0]                 duty_full_c;
    logic [PWM_W-1:0]                  lim;
    logic [PWM_W-1:0]                  duty_cl;
    logic                              blocked;

    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == pmd_pkg::ST_OUT) && (!out_valid_reg || out_ready);

    // Error terms and magnitudes
    assign err_in    = ERR_W'(target_position) - ERR_W'(encoder_count);
    assign delta_c   = DELTA_W'(err_reg) - DELTA_W'(last_error_reg);
    assign err_mag   = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign delta_mag = delta_reg[DELTA_W-1] ? DELTA_W'(-delta_reg) : DELTA_W'(delta_reg);
    assign acc_mag   = err_accum_reg[ACC_W-1] ? ACC_W'(-err_accum_reg) : ACC_W'(err_accum_reg);
    assign gp_mag    = gain_prop_reg[GAIN_W-1] ? GAIN_W'(-gain_prop_reg) : GAIN_W'(gain_prop_reg);
    assign gi_mag    = gain_integ_reg[GAIN_W-1] ? GAIN_W'(-gain_integ_reg)
                                                : GAIN_W'(gain_integ_reg);
    assign gd_mag    = gain_deriv_reg[GAIN_W-1] ? GAIN_W'(-gain_deriv_reg)
                                                : GAIN_W'(gain_deriv_reg);
    assign d_neg     = gain_deriv_reg[GAIN_W-1] ^ delta_reg[DELTA_W-1];

    // Pick multiplier operands and product sign for the current operation
    always_comb
    begin
        mul_req.start = (state_reg == pmd_pkg::ST_MUL_GO);
        unique case (op_reg)
            pmd_pkg::OP_ACC:
            begin
                mul_req.a_mag = pmd_pkg::MAG_A_W'(err_mag);
                mul_req.b_mag = pmd_pkg::MAG_B_W'(dt_reg);
                mul_neg       = err_reg[ERR_W-1];
            end
            pmd_pkg::OP_PROP:
            begin
                mul_req.a_mag = pmd_pkg::MAG_A_W'(err_mag);
                mul_req.b_mag = pmd_pkg::MAG_B_W'(gp_mag);
                mul_neg       = gain_prop_reg[GAIN_W-1] ^ err_reg[ERR_W-1];
            end
            pmd_pkg::OP_INTEG:
            begin
                mul_req.a_mag = pmd_pkg::MAG_A_W'(acc_mag);
                mul_req.b_mag = pmd_pkg::MAG_B_W'(gi_mag);
                mul_neg       = gain_integ_reg[GAIN_W-1] ^ err_accum_reg[ACC_W-1];
            end
            pmd_pkg::OP_DERIV:
            begin
                mul_req.a_mag = pmd_pkg::MAG_A_W'(delta_mag);
                mul_req.b_mag = pmd_pkg::MAG_B_W'(gd_mag);
                mul_neg       = d_neg;
            end
        endcase
    end

    assign div_req.start    = (state_reg == pmd_pkg::ST_DIV_GO);
    assign div_req.dividend = d_mag_reg;
    assign div_req.divisor  = dt_reg;

    assign mul_term = mul_neg ? -$signed({1'b0, mul_rsp.value}) : $signed({1'b0, mul_rsp.value});
    assign div_term = d_neg ? -$signed({1'b0, div_rsp.value}) : $signed({1'b0, div_rsp.value});

    pmd_mul u_pmd_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pmd_div u_pmd_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Saturating integral update
    always_comb
    begin
        acc_sum = ACC_X_W'(err_accum_reg) + ACC_X_W'(acc_inc_reg);
        if (acc_sum[ACC_X_W-1] != acc_sum[ACC_W-1])
        begin
            acc_next = acc_sum[ACC_X_W-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // PID sum, magnitude and duty
    assign sum_c       = SUM_W'(p_term_reg) + SUM_W'(i_term_reg) + SUM_W'(d_term_reg);
    assign sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign duty_full_c = DUTY_W'(sum_mag >> GAIN_FRAC_BITS);

    always_comb
    begin
        lim = (PWM_W'(pwm_limit_reg) < PWM_W'(PWM_MAX)) ? PWM_W'(pwm_limit_reg)
                                                       : PWM_W'(PWM_MAX);
        duty_cl = (duty_full_reg > DUTY_W'(lim)) ? lim : PWM_W'(duty_full_reg);
        blocked = all_blk_reg || (fwd_dir_reg ? fwd_blk_reg : rev_blk_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            pmd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = pmd_pkg::ST_PREP;
                end
            end
            pmd_pkg::ST_PREP:
            begin
                op_next    = pmd_pkg::OP_ACC;
                state_next = pmd_pkg::ST_MUL_GO;
            end
            pmd_pkg::ST_MUL_GO:
            begin
                state_next = pmd_pkg::ST_MUL_WAIT;
            end
            pmd_pkg::ST_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    unique case (op_reg)
                        pmd_pkg::OP_ACC:
                        begin
                            state_next = pmd_pkg::ST_ACC_ADD;
                        end
                        pmd_pkg::OP_PROP:
                        begin
                            op_next    = pmd_pkg::OP_INTEG;
                            state_next = pmd_pkg::ST_MUL_GO;
                        end
                        pmd_pkg::OP_INTEG:
                        begin
                            op_next    = pmd_pkg::OP_DERIV;
                            state_next = pmd_pkg::ST_MUL_GO;
                        end
                        pmd_pkg::OP_DERIV:
                        begin
                            state_next = (dt_reg == '0) ? pmd_pkg::ST_SUM : pmd_pkg::ST_DIV_GO;
                        end
                    endcase
                end
            end
            pmd_pkg::ST_ACC_ADD:
            begin
                op_next    = pmd_pkg::OP_PROP;
                state_next = pmd_pkg::ST_MUL_GO;
            end
            pmd_pkg::ST_DIV_GO:
            begin
                state_next = pmd_pkg::ST_DIV_WAIT;
            end
            pmd_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = pmd_pkg::ST_SUM;
                end
            end
            pmd_pkg::ST_SUM:
            begin
                state_next = pmd_pkg::ST_MAG;
            end
            pmd_pkg::ST_MAG:
            begin
                state_next = pmd_pkg::ST_OUT;
            end
            pmd_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = pmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmd_pkg::ST_IDLE;
            end
        endcase
    end

    // State, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmd_pkg::ST_IDLE;
            op_reg         <= pmd_pkg::OP_ACC;
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            pwm_limit_reg  <= '1;
            err_accum_reg  <= '0;
            last_error_reg <= '0;
            last_dir_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            // Take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pmd_pkg::REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    pmd_pkg::REG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    pmd_pkg::REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    pmd_pkg::REG_PWM_LIMIT:  pwm_limit_reg  <= cfg_data[pmd_pkg::LIM_W-1:0];
                endcase
            end

            // Advance the loop state
            if (state_reg == pmd_pkg::ST_PREP)
            begin
                last_error_reg <= err_reg;
            end
            if (state_reg == pmd_pkg::ST_ACC_ADD)
            begin
                err_accum_reg <= acc_next;
            end
            if (out_load && !blocked)
            begin
                last_dir_reg <= !fwd_dir_reg;
            end

            // Hold the result until taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Step datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg     <= encoder_count;
            dt_reg      <= elapsed_us;
            fwd_blk_reg <= fwd_limit_hit;
            rev_blk_reg <= rev_limit_hit;
            all_blk_reg <= watchdog_trip || supervisor_halt;
            err_reg     <= err_in;
        end
        if (state_reg == pmd_pkg::ST_PREP)
        begin
            delta_reg <= delta_c;
        end
        if (state_reg == pmd_pkg::ST_MUL_WAIT && mul_rsp.done)
        begin
            case (op_reg)
                pmd_pkg::OP_ACC:   acc_inc_reg <= mul_term;
                pmd_pkg::OP_PROP:  p_term_reg  <= mul_term;
                pmd_pkg::OP_INTEG: i_term_reg  <= mul_term;
                default:
                begin
                    d_mag_reg  <= mul_rsp.value;
                    d_term_reg <= '0;
                end
            endcase
        end
        if (state_reg == pmd_pkg::ST_DIV_WAIT && div_rsp.done)
        begin
            d_term_reg <= div_term;
        end
        if (state_reg == pmd_pkg::ST_SUM)
        begin
            sum_reg <= sum_c;
        end
        if (state_reg == pmd_pkg::ST_MAG)
        begin
            duty_full_reg <= duty_full_c;
            fwd_dir_reg   <= !sum_reg[SUM_W-1] && (duty_full_c != '0);
        end
        if (out_load)
        begin
            pwm_duty_reg    <= blocked ? '0 : duty_cl[pmd_pkg::DUTY_OUT_W-1:0];
            reverse_dir_reg <= blocked ? last_dir_reg : !fwd_dir_reg;
            blocked_reg     <= blocked;
            echo_reg        <= pos_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_duty      = pwm_duty_reg;
    assign reverse_dir   = reverse_dir_reg;
    assign drive_blocked = blocked_reg;
    assign position_echo = echo_reg;

endmodule

`default_nettype wire

[design/pmd_checker.sv]
`default_nettype none

`include "pid_position_motor_drive_defines.svh"

module pmd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [pmd_pkg::DUTY_OUT_W-1:0]     pwm_duty,
    input  logic                               reverse_dir,
    input  logic                               drive_blocked,
    input  logic [pmd_pkg::POS_W-1:0]          position_echo
);

    logic [pmd_pkg::DUTY_OUT_W+pmd_pkg::POS_W+1:0] out_bus;

    // Gather the result fields
    assign out_bus = {pwm_duty, reverse_dir, drive_blocked, position_echo};

    // Busy right after taking a transaction
    `PMD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // A result never shows up the cycle after an accept
    `PMD_ASSERT_NXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "early result")

    // A blocked drive carries zero duty
    `PMD_ASSERT_IMP(a_blocked_zero, out_valid && drive_blocked, pwm_duty == '0, "blocked duty")

    // A stalled result holds
    `PMD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus), "result moved")

endmodule

bind pid_position_motor_drive pmd_checker u_pmd_checker (.*);

`default_nettype wire
